FILE: hdl/fqs_pkg.sv
`default_nettype none

package fqs_pkg;

  typedef logic signed [31:0] word_t;

  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/fqs_ram.sv
`default_nettype none

module fqs_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire fqs_pkg::mem_cmd_t cmd_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire fqs_pkg::word_t   wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output fqs_pkg::word_t        rdata_o
);

  fqs_pkg::word_t mem [DEPTH];
  fqs_pkg::word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/fqs_ctrl.sv
`default_nettype none

module fqs_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        kind_i,
  input  wire fqs_pkg::word_t    value_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic                   found_o,
  output fqs_pkg::word_t         popped_value_o,
  output logic [4:0]             count_o,
  output fqs_pkg::mem_cmd_t      cmd_o,
  output logic [AW-1:0]          waddr_o,
  output fqs_pkg::word_t         wdata_o,
  output logic [AW-1:0]          raddr_o,
  input  wire fqs_pkg::word_t    rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN
  } state_e;

  state_e         state_q, state_d;
  fqs_pkg::word_t value_q, value_d;
  logic [AW-1:0]  head_q, head_d;
  logic [AW-1:0]  tail_q, tail_d;
  logic [AW-1:0]  addr_q, addr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  left_q, left_d;
  logic           done_q, done_d;
  logic [1:0]     status_q, status_d;
  logic           found_q, found_d;
  fqs_pkg::word_t popped_q, popped_d;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
    next_slot = (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  always_comb begin
    state_d  = state_q;
    value_d  = value_q;
    head_d   = head_q;
    tail_d   = tail_q;
    addr_d   = addr_q;
    cnt_d    = cnt_q;
    left_d   = left_q;
    done_d   = 1'b0;
    status_d = status_q;
    found_d  = found_q;
    popped_d = popped_q;
    cmd_o    = '0;
    raddr_o  = head_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          value_d  = value_i;
          status_d = fqs_pkg::STATUS_OK;
          found_d  = 1'b0;
          popped_d = '0;
          case (kind_i)
            fqs_pkg::KIND_PUSH: begin
              done_d = 1'b1;
              if (cnt_q >= CW'(DEPTH)) begin
                status_d = fqs_pkg::STATUS_FULL;
              end else begin
                cmd_o.wr_en = 1'b1;
                tail_d      = next_slot(tail_q);
                cnt_d       = cnt_q + 1'b1;
              end
            end
            fqs_pkg::KIND_POP: begin
              if (cnt_q == '0) begin
                status_d = fqs_pkg::STATUS_EMPTY;
                done_d   = 1'b1;
              end else begin
                cmd_o.rd_en = 1'b1;
                state_d     = S_POP;
              end
            end
            fqs_pkg::KIND_SEARCH: begin
              if (cnt_q == '0) begin
                done_d = 1'b1;
              end else begin
                cmd_o.rd_en = 1'b1;
                addr_d      = next_slot(head_q);
                left_d      = cnt_q;
                state_d     = S_SCAN;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        popped_d = rdata_i;
        head_d   = next_slot(head_q);
        cnt_d    = cnt_q - 1'b1;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        raddr_o     = addr_q;
        addr_d      = next_slot(addr_q);
        if (rdata_i == value_q) begin
          found_d = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (left_q == CW'(1)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          left_d = left_q - 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      addr_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      addr_q  <= addr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    found_q  <= found_d;
    popped_q <= popped_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign popped_value_o = popped_q;
  assign count_o        = 5'(cnt_q);
  assign waddr_o        = tail_q;
  assign wdata_o        = value_i;

endmodule

`default_nettype wire

FILE: hdl/fifo_queue_with_search.sv
// First-in first-out queue of signed 32-bit values with push, pop and a
// membership search, held in a ring memory of DEPTH entries with one write
// and one registered read port. An item is taken when start_i is high and
// busy_o is low, and its result shows for exactly one cycle with done_o
// high; the receiver cannot stall, so it must take the result in that
// cycle. A push, an unused kind and a pop or search on an empty queue
// leave busy_o low; a pop from a queue that holds entries waits in S_POP
// for the registered memory read, and a search reads the head and then
// compares entries in S_SCAN, from the head up to the first match, at most
// count entries, since the read port delivers one entry per cycle. The
// result is registered and appears in the cycle after the last working
// cycle of its item.
`default_nettype none

module fifo_queue_with_search #(
  parameter int DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [1:0]          kind_i,
  input  wire logic signed [31:0]  value_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic                     found_o,
  output logic signed [31:0]       popped_value_o,
  output logic [4:0]               count_o
);

  localparam int AW = $clog2(DEPTH);

  fqs_pkg::mem_cmd_t cmd;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  fqs_pkg::word_t    wdata;
  fqs_pkg::word_t    rdata;

  fqs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .found_o        (found_o),
    .popped_value_o (popped_value_o),
    .count_o        (count_o),
    .cmd_o          (cmd),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .raddr_o        (raddr),
    .rdata_i        (rdata)
  );

  fqs_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire
